>>> hw/rtl/modular_exponentiation_defines.svh
// Assertion macros for modules that check their own logic; modexp_ctrl uses them.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ME_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/modexp_pkg.sv
package modexp_pkg;

  localparam int RESULT_BITS     = 31;
  localparam int OUT_TDATA_BITS  = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_MUL_ACC,
    ST_MUL_SQ,
    ST_FINISH
  } me_state_t;

  typedef struct packed {
    logic load;
    logic red_step;
    logic mul_start;
    logic mul_sel_sq;
    logic acc_wr;
    logic sq_wr;
    logic exp_shift;
    logic out_wr;
  } me_cmd_t;

  typedef struct packed {
    logic red_last;
    logic exp_zero;
    logic exp_lsb;
    logic mod_zero;
    logic mul_done;
  } me_status_t;

endpackage

>>> hw/rtl/modexp_mulmod.sv
module modexp_mulmod #(
  parameter int N = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] a_in,
  input  logic [N-1:0] b_in,
  input  logic [N-1:0] m_in,
  output logic         done,
  output logic [N-1:0] p
);

  logic         busy;
  logic [N-1:0] a;
  logic [N-1:0] b;
  logic [N-1:0] m;

  function automatic logic [N-1:0] add_mod(input logic [N-1:0] x, input logic [N-1:0] y,
                                           input logic [N-1:0] md);
    logic [N:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, md}) begin
      s = s - {1'b0, md};
    end
    return s[N-1:0];
  endfunction

  assign done = busy && (b == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a <= a_in;
      b <= b_in;
      m <= m_in;
      p <= '0;
    end else if (busy && (b != '0)) begin
      if (b[0]) begin
        p <= add_mod(p, a, m);
      end
      a <= add_mod(a, a, m);
      b <= b >> 1;
    end
  end

endmodule

>>> hw/rtl/modexp_datapath.sv
module modexp_datapath #(
  parameter int N = 31
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  modexp_pkg::me_cmd_t                  cmd,
  output modexp_pkg::me_status_t               status,
  input  logic [N-1:0]                         base_in,
  input  logic [N-1:0]                         exponent_in,
  input  logic [N-1:0]                         modulus_in,
  output logic [modexp_pkg::RESULT_BITS-1:0]   result,
  output logic                                 mod_error
);

  import modexp_pkg::*;

  localparam int CW = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0]  expo;
  logic [N-1:0]  modv;
  logic [N-1:0]  bsh;
  logic [N-1:0]  rem;
  logic [CW-1:0] cnt;
  logic [N-1:0]  sq;
  logic [N-1:0]  acc;

  logic [N:0]    trial;
  logic [N-1:0]  rem_next;
  logic [N-1:0]  acc_red;
  logic [N-1:0]  mul_a;
  logic          mul_done;
  logic [N-1:0]  prod;

  assign trial    = {rem, bsh[N-1]};
  assign rem_next = (trial >= {1'b0, modv}) ? N'(trial - {1'b0, modv}) : trial[N-1:0];

  // The accumulator is 1 or already below the modulus, so one subtraction reduces it.
  assign acc_red = (acc >= modv) ? (acc - modv) : acc;
  assign mul_a   = cmd.mul_sel_sq ? sq : acc_red;

  modexp_mulmod #(.N(N)) u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a_in  (mul_a),
    .b_in  (sq),
    .m_in  (modv),
    .done  (mul_done),
    .p     (prod)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bsh  <= base_in;
      expo <= exponent_in;
      modv <= modulus_in;
      rem  <= '0;
      cnt  <= '0;
      acc  <= N'(1);
    end else begin
      if (cmd.red_step) begin
        rem <= rem_next;
        bsh <= bsh << 1;
        cnt <= cnt + 1'b1;
        if (status.red_last) begin
          sq <= rem_next;
        end
      end
      if (cmd.acc_wr) begin
        acc <= prod;
      end
      if (cmd.sq_wr) begin
        sq <= prod;
      end
      if (cmd.exp_shift) begin
        expo <= expo >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_wr) begin
      result    <= status.mod_zero ? '0 : RESULT_BITS'(acc);
      mod_error <= status.mod_zero;
    end
  end

  assign status.red_last = (cnt == CW'(N - 1));
  assign status.exp_zero = (expo == '0);
  assign status.exp_lsb  = expo[0];
  assign status.mod_zero = (modv == '0);
  assign status.mul_done = mul_done;

endmodule

>>> hw/rtl/modexp_ctrl.sv
`include "modular_exponentiation_defines.svh"

module modexp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  modexp_pkg::me_status_t status,
  output modexp_pkg::me_cmd_t    cmd
);

  import modexp_pkg::*;

  me_state_t state;
  me_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_wr) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (status.red_last) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (status.mod_zero || status.exp_zero) begin
          state_next = ST_FINISH;
        end else if (status.exp_lsb) begin
          state_next = ST_MUL_ACC;
        end else begin
          state_next = ST_MUL_SQ;
        end
      end
      ST_MUL_ACC: begin
        if (status.mul_done) begin
          state_next = ST_MUL_SQ;
        end
      end
      ST_MUL_SQ: begin
        if (status.mul_done) begin
          state_next = ST_STEP;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_REDUCE: begin
        cmd.red_step = 1'b1;
      end
      ST_STEP: begin
        if (!status.mod_zero && !status.exp_zero) begin
          cmd.mul_start  = 1'b1;
          cmd.mul_sel_sq = !status.exp_lsb;
        end
      end
      ST_MUL_ACC: begin
        if (status.mul_done) begin
          cmd.acc_wr     = 1'b1;
          cmd.mul_start  = 1'b1;
          cmd.mul_sel_sq = 1'b1;
        end
      end
      ST_MUL_SQ: begin
        if (status.mul_done) begin
          cmd.sq_wr     = 1'b1;
          cmd.exp_shift = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd.out_wr = !out_valid || out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `ME_ASSERT_NOW(a_no_overwrite, cmd.out_wr, !out_valid || out_ready, "Result overwritten before it was taken.")
  `ME_ASSERT_NEXT(a_accept_reduce, in_valid && in_ready, state == ST_REDUCE, "Accepted transaction did not start reduction.")
  `ME_ASSERT_NEXT(a_mul_follows, cmd.mul_start, state == ST_MUL_ACC || state == ST_MUL_SQ, "Multiplication started outside a multiply state.")
  `ME_ASSERT_NOW(a_no_mul_on_zero, cmd.mul_start, !status.mod_zero, "Multiplication started with a zero modulus.")

endmodule

>>> hw/rtl/modular_exponentiation.sv
// Computes base^exponent mod modulus by right-to-left binary exponentiation, one transaction
// at a time; a zero modulus returns 0 with mod_error set. After a transaction is accepted the
// base is reduced by the modulus. Each exponent bit up to the highest set one then takes a
// step state and a squaring, and a set bit also takes a multiplication into the accumulator.
// Both run on a shared shift-and-add modular multiplier that consumes one multiplier bit per
// cycle. A finished result is held in an output register, so the next transaction is accepted
// while it waits to be taken.
module modular_exponentiation #(
  parameter int OPERAND_BITS = 31
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // base, exponent, modulus from the lowest bit up, zero padded to whole bytes
  input  logic [((3*OPERAND_BITS+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // result, zero padded to whole bytes
  output logic [modexp_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,
  // mod_error
  output logic                                    m_axis_tuser
);

  import modexp_pkg::*;

  localparam int N = OPERAND_BITS;

  me_cmd_t                cmd;
  me_status_t             status;
  logic [RESULT_BITS-1:0] result;

  modexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  modexp_datapath #(.N(N)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .base_in     (s_axis_tdata[N-1:0]),
    .exponent_in (s_axis_tdata[2*N-1:N]),
    .modulus_in  (s_axis_tdata[3*N-1:2*N]),
    .result      (result),
    .mod_error   (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_TDATA_BITS'(result);

endmodule
